@@ rtl/core/amalu_pkg.sv @@
package amalu_pkg;

    localparam int ADDR_WORDS   = 256;
    localparam int ADDR_BITS    = (ADDR_WORDS > 1) ? $clog2(ADDR_WORDS) : 1;
    localparam int WORD_BITS    = 32;
    localparam int MODE_BITS    = 4;
    localparam int IN_ADDR_BITS = 8;

    typedef logic [ADDR_BITS-1:0] word_addr_t;
    typedef logic [WORD_BITS-1:0] word_t;

    typedef enum logic [MODE_BITS-1:0] {
        MODE_ADD     = 4'd0,
        MODE_SUB     = 4'd1,
        MODE_INC     = 4'd2,
        MODE_DEC     = 4'd3,
        MODE_XCHG    = 4'd4,
        MODE_CMPXCHG = 4'd5,
        MODE_SMIN    = 4'd6,
        MODE_SMAX    = 4'd7,
        MODE_UMIN    = 4'd8,
        MODE_UMAX    = 4'd9,
        MODE_AND     = 4'd10,
        MODE_OR      = 4'd11,
        MODE_XOR     = 4'd12
    } mode_t;

    typedef struct packed {
        logic       en;
        word_addr_t addr;
        word_t      data;
    } wr_port_t;

    // Reduces a request address modulo the memory depth by restoring subtraction.
    function automatic word_addr_t wrap_address(logic [IN_ADDR_BITS-1:0] a);
        logic [31:0] rem;
        rem = 32'(a);
        for (int k = IN_ADDR_BITS - 1; k >= 0; k--) begin
            if (rem >= (32'(ADDR_WORDS) << k)) begin
                rem = rem - (32'(ADDR_WORDS) << k);
            end
        end
        return word_addr_t'(rem);
    endfunction

endpackage

@@ rtl/core/atomic_memory_alu.sv @@
// Atomic read-modify-write unit over a memory of 256 words of 32 bits, all zero
// after reset, with no clearing pass needed because per-word valid bits make
// unwritten words read as zero. Each transaction reads its word from the
// synchronous memory, applies the operation in the next cycle, writes the
// result back and returns the old value; the old value passes through the
// stage-1 registers and the output register, and is held while the output is
// stalled. The unit sustains one transaction per cycle while the output is not
// stalled; a write-back register forwards the last written word so that
// back-to-back transactions to the same word see each other's results.
module atomic_memory_alu
    import amalu_pkg::*;
(
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    s_valid,
    output logic                    s_ready,
    input  logic [MODE_BITS-1:0]    s_mode,
    input  logic [IN_ADDR_BITS-1:0] s_address,
    input  logic [WORD_BITS-1:0]    s_operand,
    input  logic [WORD_BITS-1:0]    s_compare_value,
    output logic                    m_valid,
    input  logic                    m_ready,
    output logic [WORD_BITS-1:0]    m_old_value
);

    logic                 s1_valid_reg;
    logic [MODE_BITS-1:0] s1_mode_reg;
    word_addr_t           s1_addr_reg;
    word_t                s1_operand_reg;
    word_t                s1_compare_reg;

    logic       fwd_valid_reg;
    word_addr_t fwd_addr_reg;
    word_t      fwd_data_reg;

    logic  m_valid_reg;
    word_t m_old_value_reg;

    logic       out_free;
    logic       s1_fire;
    logic       s_fire;
    word_addr_t in_addr;
    word_t      rd_data;
    word_t      old_word;
    word_t      new_word;
    wr_port_t   wr;

    assign out_free = !m_valid_reg || m_ready;
    assign s1_fire  = s1_valid_reg && out_free;
    assign s_ready  = !s1_valid_reg || s1_fire;
    assign s_fire   = s_valid && s_ready;
    assign in_addr  = wrap_address(s_address);

    assign old_word = (fwd_valid_reg && (fwd_addr_reg == s1_addr_reg)) ? fwd_data_reg : rd_data;

    assign wr.en   = s1_fire;
    assign wr.addr = s1_addr_reg;
    assign wr.data = new_word;

    amalu_ram u_ram (
        .aclk    (aclk),
        .aresetn (aresetn),
        .rd_en   (s_fire),
        .rd_addr (in_addr),
        .rd_data (rd_data),
        .wr      (wr)
    );

    amalu_op u_op (
        .mode          (s1_mode_reg),
        .old_word      (old_word),
        .operand       (s1_operand_reg),
        .compare_value (s1_compare_reg),
        .new_word      (new_word)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg  <= 1'b0;
            fwd_valid_reg <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            if (s_ready) begin
                s1_valid_reg <= s_valid;
            end
            if (s1_fire) begin
                fwd_valid_reg <= 1'b1;
            end
            if (out_free) begin
                m_valid_reg <= s1_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            s1_mode_reg    <= s_mode;
            s1_addr_reg    <= in_addr;
            s1_operand_reg <= s_operand;
            s1_compare_reg <= s_compare_value;
        end
        if (s1_fire) begin
            fwd_addr_reg    <= s1_addr_reg;
            fwd_data_reg    <= new_word;
            m_old_value_reg <= old_word;
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_old_value = m_old_value_reg;

endmodule

@@ rtl/core/amalu_ram.sv @@
module amalu_ram
    import amalu_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       rd_en,
    input  word_addr_t rd_addr,
    output word_t      rd_data,
    input  wr_port_t   wr
);

    word_t                 word_mem [ADDR_WORDS];
    logic [ADDR_WORDS-1:0] filled_reg;
    word_t                 rd_word_reg;
    logic                  rd_filled_reg;

    always_ff @(posedge aclk) begin
        if (wr.en) begin
            word_mem[wr.addr] <= wr.data;
        end
        if (rd_en) begin
            rd_word_reg <= word_mem[rd_addr];
        end
    end

    // A word that was never written since reset reads as zero.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            filled_reg    <= '0;
            rd_filled_reg <= 1'b0;
        end else begin
            if (wr.en) begin
                filled_reg[wr.addr] <= 1'b1;
            end
            if (rd_en) begin
                rd_filled_reg <= filled_reg[rd_addr];
            end
        end
    end

    assign rd_data = rd_filled_reg ? rd_word_reg : '0;

endmodule

@@ rtl/core/amalu_op.sv @@
module amalu_op
    import amalu_pkg::*;
(
    input  logic [MODE_BITS-1:0] mode,
    input  word_t                old_word,
    input  word_t                operand,
    input  word_t                compare_value,
    output word_t                new_word
);

    always_comb begin
        case (mode)
            MODE_ADD:     new_word = old_word + operand;
            MODE_SUB:     new_word = old_word - operand;
            MODE_INC:     new_word = old_word + word_t'(1);
            MODE_DEC:     new_word = old_word - word_t'(1);
            MODE_XCHG:    new_word = operand;
            MODE_CMPXCHG: new_word = (old_word == compare_value) ? operand : old_word;
            MODE_SMIN:    new_word = ($signed(operand) < $signed(old_word)) ? operand : old_word;
            MODE_SMAX:    new_word = ($signed(old_word) < $signed(operand)) ? operand : old_word;
            MODE_UMIN:    new_word = (operand < old_word) ? operand : old_word;
            MODE_UMAX:    new_word = (operand > old_word) ? operand : old_word;
            MODE_AND:     new_word = old_word & operand;
            MODE_OR:      new_word = old_word | operand;
            MODE_XOR:     new_word = old_word ^ operand;
            default:      new_word = old_word;
        endcase
    end

endmodule
